// ----- design/point_in_mesh_parity_test_core_macros.svh -----
// Assertion macros used by the mesh parity test back end.
`ifndef POINT_IN_MESH_PARITY_TEST_CORE_MACROS_SVH
`define POINT_IN_MESH_PARITY_TEST_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PIMPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PIMPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PIMPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PIMPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/pimpt_pkg.sv -----
// Shared types and constants of the mesh parity test.
`default_nettype none
package pimpt_pkg;

  // field slots of a queue word, each one difference wide
  localparam int FLD_UX  = 0;
  localparam int FLD_UY  = 1;
  localparam int FLD_UZ  = 2;
  localparam int FLD_VX  = 3;
  localparam int FLD_VY  = 4;
  localparam int FLD_VZ  = 5;
  localparam int FLD_E1X = 6;
  localparam int FLD_E1Y = 7;
  localparam int FLD_Q1X = 8;
  localparam int FLD_Q1Y = 9;
  localparam int FLD_E2X = 10;
  localparam int FLD_E2Y = 11;
  localparam int FLD_Q2X = 12;
  localparam int FLD_Q2Y = 13;
  localparam int FLD_E3X = 14;
  localparam int FLD_E3Y = 15;
  localparam int FLD_Q3X = 16;
  localparam int FLD_Q3Y = 17;
  localparam int FLD_DZ  = 18;
  localparam int FLD_DX  = 19;
  localparam int FLD_DY  = 20;
  localparam int NFLD    = 21;

  // flag bits above the fields
  localparam int FLG_BELOW = 0;
  localparam int FLG_ABOVE = 1;
  localparam int FLG_LAST  = 2;
  localparam int NFLG      = 3;

  localparam int QDEPTH = 2;

  // register indexes
  localparam logic [1:0] REG_QX = 2'd0;
  localparam logic [1:0] REG_QY = 2'd1;
  localparam logic [1:0] REG_QZ = 2'd2;

  typedef enum logic [3:0] {
    STEP_NZ_A, STEP_NZ_B,
    STEP_D1_A, STEP_D1_B,
    STEP_D2_A, STEP_D2_B,
    STEP_D3_A, STEP_D3_B,
    STEP_NX_A, STEP_NX_B,
    STEP_NY_A, STEP_NY_B,
    STEP_S_Z, STEP_S_X, STEP_S_Y
  } step_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  typedef struct packed {
    logic start;
    logic accum;
    logic neg;
  } mac_ctl_t;

endpackage
`default_nettype wire

// ----- design/pimpt_if.sv -----
// Triangle and result channel interfaces.
`default_nettype none
interface pimpt_in_if #(parameter int CB = 32);
  logic          valid;
  logic          ready;
  logic [CB-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  logic          last_triangle;
  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_triangle,
                  input ready);
  modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_triangle,
                output ready);
endinterface

interface pimpt_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface
`default_nettype wire

// ----- design/pimpt_front.sv -----
// Front end: take triangle words, form differences and z classes.
`default_nettype none
module pimpt_front import pimpt_pkg::*; #(
  parameter int CB = 32,
  parameter int D  = CB + 1,
  parameter int EW = NFLD * D + NFLG
) (
  pimpt_in_if.sink                in_ch,
  input  wire logic signed [CB-1:0] qx,
  input  wire logic signed [CB-1:0] qy,
  input  wire logic signed [CB-1:0] qz,
  input  wire logic                 q_ready,
  output logic                      q_push,
  output logic [EW-1:0]             q_din
);

  function automatic logic signed [D-1:0] dif(input logic signed [CB-1:0] p,
                                               input logic signed [CB-1:0] q);
    return {p[CB-1], p} - {q[CB-1], q};
  endfunction

  logic signed [CB-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  logic [D-1:0] fld [NFLD];

  assign ax = in_ch.ax;
  assign ay = in_ch.ay;
  assign az = in_ch.az;
  assign bx = in_ch.bx;
  assign by = in_ch.by;
  assign bz = in_ch.bz;
  assign cx = in_ch.cx;
  assign cy = in_ch.cy;
  assign cz = in_ch.cz;

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid & q_ready;

  always_comb begin
    fld[FLD_UX]  = dif(bx, ax);
    fld[FLD_UY]  = dif(by, ay);
    fld[FLD_UZ]  = dif(bz, az);
    fld[FLD_VX]  = dif(cx, ax);
    fld[FLD_VY]  = dif(cy, ay);
    fld[FLD_VZ]  = dif(cz, az);
    fld[FLD_E1X] = dif(bx, ax);
    fld[FLD_E1Y] = dif(by, ay);
    fld[FLD_Q1X] = dif(qx, ax);
    fld[FLD_Q1Y] = dif(qy, ay);
    fld[FLD_E2X] = dif(cx, bx);
    fld[FLD_E2Y] = dif(cy, by);
    fld[FLD_Q2X] = dif(qx, bx);
    fld[FLD_Q2Y] = dif(qy, by);
    fld[FLD_E3X] = dif(ax, cx);
    fld[FLD_E3Y] = dif(ay, cy);
    fld[FLD_Q3X] = dif(qx, cx);
    fld[FLD_Q3Y] = dif(qy, cy);
    fld[FLD_DZ]  = dif(az, qz);
    fld[FLD_DX]  = dif(ax, qx);
    fld[FLD_DY]  = dif(ay, qy);
    for (int k = 0; k < NFLD; k++) begin
      q_din[k*D +: D] = fld[k];
    end
    q_din[NFLD*D + FLG_BELOW] = (az < qz) && (bz < qz) && (cz < qz);
    q_din[NFLD*D + FLG_ABOVE] = (az > qz) && (bz > qz) && (cz > qz);
    q_din[NFLD*D + FLG_LAST]  = in_ch.last_triangle;
  end

endmodule
`default_nettype wire

// ----- design/pimpt_queue.sv -----
// Short queue between front and back end.
`default_nettype none
module pimpt_queue import pimpt_pkg::*; #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              ready,
  output logic              valid,
  output logic [W-1:0]      dout,
  input  wire logic         pop
);

  localparam int PW = $clog2(QDEPTH);

  logic [W-1:0]  mem_r [QDEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;

  assign ready = cnt_r != (PW+1)'(QDEPTH);
  assign valid = cnt_r != '0;
  assign dout  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

endmodule
`default_nettype wire

// ----- design/pimpt_mac.sv -----
// Bit-serial signed multiply-accumulate unit.
`default_nettype none
module pimpt_mac import pimpt_pkg::*; #(
  parameter int WA = 67,
  parameter int WB = 33,
  parameter int WS = 102
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mac_ctl_t             ctl,
  input  wire logic signed [WA-1:0] a,
  input  wire logic signed [WB-1:0] b,
  output logic                      done,
  output logic signed [WS-1:0]      acc
);

  localparam int CW = $clog2(WB);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [WS-1:0] mc_r, acc_r, a_ext, addend;
  logic [WB-1:0] mp_r;
  logic          top_bit;

  assign a_ext   = {{(WS-WA){a[WA-1]}}, a};
  assign addend  = mp_r[0] ? mc_r : '0;
  assign top_bit = cnt_r == CW'(WB-1);
  assign done    = done_r;
  assign acc     = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (top_bit) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // the multiplier's sign bit carries negative weight
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= ctl.accum ? acc_r : '0;
      mc_r  <= ctl.neg ? -a_ext : a_ext;
      mp_r  <= b;
    end else if (busy_r) begin
      acc_r <= top_bit ? acc_r - addend : acc_r + addend;
      mc_r  <= mc_r << 1;
      mp_r  <= mp_r >> 1;
    end
  end

endmodule
`default_nettype wire

// ----- design/pimpt_back.sv -----
// Back end: sequence the crossing test and keep the hit parity.
`default_nettype none
`include "point_in_mesh_parity_test_core_macros.svh"
module pimpt_back import pimpt_pkg::*; #(
  parameter int CB = 32,
  parameter int D  = CB + 1,
  parameter int EW = NFLD * D + NFLG
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire logic [EW-1:0] q_dout,
  output logic               q_pop,
  pimpt_out_if.source        out_ch
);

  localparam int WM = 2 * D + 1;
  localparam int WS = 3 * D + 3;

  state_t  state_r;
  step_t   step_r;
  logic signed [WM-1:0] nz_r, nx_r, ny_r;
  logic    negf_r, posf_r, hit_r, parity_r, out_valid_r, out_bit_r;

  mac_ctl_t             mac_ctl;
  logic signed [WM-1:0] op_a;
  logic signed [D-1:0]  op_b;
  logic                 mac_done;
  logic signed [WS-1:0] acc;
  logic                 acc_nz, acc_neg, acc_pos, gate_neg, gate_pos;
  logic                 below, above, last, stall;

  function automatic logic signed [D-1:0] fld(input logic [EW-1:0] e, input int k);
    return e[k*D +: D];
  endfunction

  function automatic logic signed [WM-1:0] ext(input logic signed [D-1:0] v);
    return {{(WM-D){v[D-1]}}, v};
  endfunction

  assign below    = q_dout[NFLD*D + FLG_BELOW];
  assign above    = q_dout[NFLD*D + FLG_ABOVE];
  assign last     = q_dout[NFLD*D + FLG_LAST];
  assign acc_nz   = |acc;
  assign acc_neg  = acc[WS-1];
  assign acc_pos  = acc_nz & ~acc_neg;
  assign gate_neg = negf_r | acc_neg;
  assign gate_pos = posf_r | acc_pos;
  assign stall    = last && out_valid_r && !out_ch.ready;
  assign q_pop    = (state_r == ST_FIN) && !stall;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.inside_res = out_bit_r;

  always_comb begin
    mac_ctl.start = state_r == ST_LOAD;
    mac_ctl.accum = 1'b0;
    mac_ctl.neg   = 1'b0;
    op_a          = '0;
    op_b          = '0;
    unique case (step_r)
      STEP_NZ_A: begin op_a = ext(fld(q_dout, FLD_UX)); op_b = fld(q_dout, FLD_VY); end
      STEP_NZ_B: begin
        op_a = ext(fld(q_dout, FLD_UY)); op_b = fld(q_dout, FLD_VX);
        mac_ctl.accum = 1'b1; mac_ctl.neg = 1'b1;
      end
      STEP_D1_A: begin op_a = ext(fld(q_dout, FLD_E1X)); op_b = fld(q_dout, FLD_Q1Y); end
      STEP_D1_B: begin
        op_a = ext(fld(q_dout, FLD_E1Y)); op_b = fld(q_dout, FLD_Q1X);
        mac_ctl.accum = 1'b1; mac_ctl.neg = 1'b1;
      end
      STEP_D2_A: begin op_a = ext(fld(q_dout, FLD_E2X)); op_b = fld(q_dout, FLD_Q2Y); end
      STEP_D2_B: begin
        op_a = ext(fld(q_dout, FLD_E2Y)); op_b = fld(q_dout, FLD_Q2X);
        mac_ctl.accum = 1'b1; mac_ctl.neg = 1'b1;
      end
      STEP_D3_A: begin op_a = ext(fld(q_dout, FLD_E3X)); op_b = fld(q_dout, FLD_Q3Y); end
      STEP_D3_B: begin
        op_a = ext(fld(q_dout, FLD_E3Y)); op_b = fld(q_dout, FLD_Q3X);
        mac_ctl.accum = 1'b1; mac_ctl.neg = 1'b1;
      end
      STEP_NX_A: begin op_a = ext(fld(q_dout, FLD_UY)); op_b = fld(q_dout, FLD_VZ); end
      STEP_NX_B: begin
        op_a = ext(fld(q_dout, FLD_UZ)); op_b = fld(q_dout, FLD_VY);
        mac_ctl.accum = 1'b1; mac_ctl.neg = 1'b1;
      end
      STEP_NY_A: begin op_a = ext(fld(q_dout, FLD_UZ)); op_b = fld(q_dout, FLD_VX); end
      STEP_NY_B: begin
        op_a = ext(fld(q_dout, FLD_UX)); op_b = fld(q_dout, FLD_VZ);
        mac_ctl.accum = 1'b1; mac_ctl.neg = 1'b1;
      end
      STEP_S_Z: begin op_a = nz_r; op_b = fld(q_dout, FLD_DZ); end
      STEP_S_X: begin op_a = nx_r; op_b = fld(q_dout, FLD_DX); mac_ctl.accum = 1'b1; end
      STEP_S_Y: begin op_a = ny_r; op_b = fld(q_dout, FLD_DY); mac_ctl.accum = 1'b1; end
      default: ;
    endcase
  end

  pimpt_mac #(.WA(WM), .WB(D), .WS(WS)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (op_a),
    .b     (op_b),
    .done  (mac_done),
    .acc   (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            state_r <= below ? ST_FIN : ST_LOAD;
          end
        end
        ST_LOAD: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (mac_done) begin
            state_r <= ST_LOAD;
            unique case (step_r)
              STEP_NZ_B: if (!acc_nz) state_r <= ST_FIN;
              STEP_D3_B: if ((gate_neg && gate_pos) || above) state_r <= ST_FIN;
              STEP_S_Y:  state_r <= ST_FIN;
              default: ;
            endcase
          end
        end
        ST_FIN: begin
          if (!stall) begin
            state_r <= ST_IDLE;
            if (last) begin
              out_valid_r <= 1'b1;
              parity_r    <= 1'b0;
            end else begin
              parity_r <= parity_r ^ hit_r;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // payload of the sequencer
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_valid) begin
      step_r <= STEP_NZ_A;
      negf_r <= 1'b0;
      posf_r <= 1'b0;
      hit_r  <= 1'b0;
    end
    if (state_r == ST_WAIT && mac_done) begin
      step_r <= step_t'(step_r + 1'b1);
      unique case (step_r)
        STEP_NZ_B: nz_r <= acc[WM-1:0];
        STEP_D1_B, STEP_D2_B: begin
          negf_r <= gate_neg;
          posf_r <= gate_pos;
        end
        STEP_D3_B: if (!(gate_neg && gate_pos) && above) hit_r <= 1'b1;
        STEP_NX_B: nx_r <= acc[WM-1:0];
        STEP_NY_B: ny_r <= acc[WM-1:0];
        STEP_S_Y:  hit_r <= acc_nz && (acc_neg == nz_r[WM-1]);
        default: ;
      endcase
    end
    if (q_pop && last) out_bit_r <= parity_r ^ hit_r;
  end

  `PIMPT_ASSERT_IMP(a_pop_in_fin, clk, rst_n, q_pop, state_r == ST_FIN && q_valid)
  `PIMPT_ASSERT_IMP(a_done_in_wait, clk, rst_n, mac_done, state_r == ST_WAIT)
  `PIMPT_ASSERT_NXT(a_load_then_wait, clk, rst_n, state_r == ST_LOAD, state_r == ST_WAIT)

endmodule
`default_nettype wire

// ----- design/point_in_mesh_parity_test_core.sv -----
// Top level of the point-in-mesh parity test.
// Casts a ray from the query point (configuration registers, signed fixed point) toward +z
// and toggles a parity bit for each triangle it crosses; the word carrying last_triangle
// yields one inside_res word and clears the parity. The front end takes one triangle per
// cycle into a two-word queue while the queue has room. The back end runs up to fifteen
// exact products through one bit-serial multiply-accumulate unit.
// The back end runs no product for a triangle below the point, two for a degenerate one,
// eight for one wholly above the point, and fifteen for a full plane test. That unit sets
// the sustained rate.
`default_nettype none
module point_in_mesh_parity_test_core import pimpt_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  parameter int PW = (COORD_BITS > 32) ? 64 : 32,
  parameter int AW = (COORD_BITS > 32) ? 5 : 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  pimpt_in_if.sink           in_ch,
  pimpt_out_if.source        out_ch,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [AW-1:0] cfg_paddr,
  input  wire logic [PW-1:0] cfg_pwdata,
  output logic [PW-1:0]      cfg_prdata,
  output logic               cfg_pready
);

  localparam int D  = COORD_BITS + 1;
  localparam int EW = NFLD * D + NFLG;
  // scale of the fixed point moves no decision; a negative value only blocks config writes
  localparam int FB = FRAC_BITS;

  logic signed [COORD_BITS-1:0] qx_r, qy_r, qz_r, rd_val;
  logic [1:0]    idx;
  logic          wr_en;
  logic          q_push, q_ready, q_valid, q_pop;
  logic [EW-1:0] q_din, q_dout;

  assign idx        = cfg_paddr[AW-1:AW-2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && (FB >= 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_QX: qx_r <= cfg_pwdata[COORD_BITS-1:0];
        REG_QY: qy_r <= cfg_pwdata[COORD_BITS-1:0];
        REG_QZ: qz_r <= cfg_pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_QX:  rd_val = qx_r;
      REG_QY:  rd_val = qy_r;
      REG_QZ:  rd_val = qz_r;
      default: rd_val = '0;
    endcase
    cfg_prdata = PW'(rd_val);
  end

  pimpt_front #(.CB(COORD_BITS), .D(D), .EW(EW)) u_front (
    .in_ch   (in_ch),
    .qx      (qx_r),
    .qy      (qy_r),
    .qz      (qz_r),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_din   (q_din)
  );

  pimpt_queue #(.W(EW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .ready (q_ready),
    .valid (q_valid),
    .dout  (q_dout),
    .pop   (q_pop)
  );

  pimpt_back #(.CB(COORD_BITS), .D(D), .EW(EW)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_dout  (q_dout),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ----- verif/tb_point_in_mesh_parity_test_core.sv -----
// Testbench for the point-in-mesh parity test core: directed table plus random meshes.
`timescale 1ns / 1ps
`default_nettype none
module tb_point_in_mesh_parity_test_core;
  import pimpt_pkg::*;

  localparam int CB = 32;

  typedef struct {
    logic signed [CB-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic                 last;
    int                   want; // -1: use predictor
  } tri_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  pimpt_in_if #(.CB(CB)) in_ch ();
  pimpt_out_if out_ch ();

  point_in_mesh_parity_test_core #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic signed [CB-1:0] qx, qy, qz;
  logic                 parity;
  logic                 inside_q[$];
  int  errors = 0;
  int  send_idle_pct = 0, recv_stall_pct = 0;
  bit  hold_off = 1'b0;
  int  quiet = 0;

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by} = '0;
    {in_ch.bz, in_ch.cx, in_ch.cy, in_ch.cz} = '0;
    in_ch.last_triangle = 1'b0;
    out_ch.ready = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic int sgn(input logic signed [255:0] v);
    return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
  endfunction

  function automatic int xy_edge(input logic signed [255:0] x0, y0, x1, y1, px, py);
    return sgn((x1 - x0) * (py - y0) - (y1 - y0) * (px - x0));
  endfunction

  // crossing decision for one triangle against the +z ray from the query point
  function automatic bit ray_crosses(input tri_row_t t);
    logic signed [255:0] ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz;
    logic signed [255:0] ux, uy, uz, vx, vy, vz, nx, ny, nz, s;
    int d1, d2, d3, snz;
    ax = t.ax; ay = t.ay; az = t.az; bx = t.bx; by = t.by; bz = t.bz;
    cx = t.cx; cy = t.cy; cz = t.cz; px = qx; py = qy; pz = qz;
    if (az < pz && bz < pz && cz < pz) return 1'b0;
    ux = bx - ax; uy = by - ay; uz = bz - az;
    vx = cx - ax; vy = cy - ay; vz = cz - az;
    nz = ux * vy - uy * vx;
    snz = sgn(nz);
    if (snz == 0) return 1'b0;
    d1 = xy_edge(ax, ay, bx, by, px, py);
    d2 = xy_edge(bx, by, cx, cy, px, py);
    d3 = xy_edge(cx, cy, ax, ay, px, py);
    if ((d1 < 0 || d2 < 0 || d3 < 0) && (d1 > 0 || d2 > 0 || d3 > 0)) return 1'b0;
    if (az > pz && bz > pz && cz > pz) return 1'b1;
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    s = nz * (az - pz) + nx * (ax - px) + ny * (ay - py);
    return sgn(s) == snz;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_QX: qx = val;
      REG_QY: qy = val;
      default: qz = val;
    endcase
  endtask

  // offer one triangle; expectation is queued when the word is accepted
  task automatic send_tri(input tri_row_t t);
    bit hit;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.ax <= t.ax; in_ch.ay <= t.ay; in_ch.az <= t.az;
    in_ch.bx <= t.bx; in_ch.by <= t.by; in_ch.bz <= t.bz;
    in_ch.cx <= t.cx; in_ch.cy <= t.cy; in_ch.cz <= t.cz;
    in_ch.last_triangle <= t.last;
    do @(posedge clk); while (!in_ch.ready);
    hit = ray_crosses(t);
    parity ^= hit;
    if (t.last) begin
      if (t.want >= 0 && t.want != int'(parity))
        report_mismatch($sformatf("directed row expects %0d, predictor %0b", t.want, parity));
      inside_q = {inside_q, parity};
      parity = 1'b0;
    end
  endtask

  task automatic drain();
    int guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    while (inside_q.size() != 0 && guard < 400000) begin
      @(posedge clk);
      guard++;
    end
    // back end may still be chewing on a non-last triangle
    repeat (600) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] rnd_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return 32'h7fff_ffff - $urandom_range(3);
      default: return $signed($urandom_range(2000)) - 1000;
    endcase
  endfunction

  function automatic tri_row_t rnd_tri(input bit last);
    tri_row_t t;
    int r;
    t.want = -1; t.last = last;
    r = $urandom_range(9);
    if (r < 7) begin
      // triangle around the query point, small extents so hits are common
      t.ax = qx - $urandom_range(50); t.ay = qy - $urandom_range(50);
      t.bx = qx + $urandom_range(50); t.by = qy - $urandom_range(50);
      t.cx = qx + $signed($urandom_range(40)) - 20; t.cy = qy + $urandom_range(50);
      t.az = qz + $signed($urandom_range(60)) - 30;
      t.bz = qz + $signed($urandom_range(60)) - 30;
      t.cz = qz + $signed($urandom_range(60)) - 30;
      if ($urandom_range(1)) {t.bx, t.cx} = {t.cx, t.bx};
      if (r == 6) begin t.cx = t.ax; t.cy = t.ay; end
    end else begin
      t.ax = rnd_coord(); t.ay = rnd_coord(); t.az = rnd_coord();
      t.bx = rnd_coord(); t.by = rnd_coord(); t.bz = rnd_coord();
      t.cx = rnd_coord(); t.cy = rnd_coord(); t.cz = rnd_coord();
    end
    return t;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (inside_q.size() == 0)
        report_mismatch("inside_res word with no expectation");
      else if (out_ch.inside_res !== inside_q.pop_front())
        report_mismatch($sformatf("inside_res %b wrong", out_ch.inside_res));
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // watchdog on accepted words
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 200000) begin
      $display("tb_point_in_mesh_parity_test_core: done, errors");
      $finish;
    end
  end

  tri_row_t dir_rows[$];

  task automatic add_row(input logic [CB-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2,
                         input logic lst, input int w);
    tri_row_t t;
    t.ax = a0; t.ay = a1; t.az = a2; t.bx = b0; t.by = b1; t.bz = b2;
    t.cx = c0; t.cy = c1; t.cz = c2; t.last = lst; t.want = w;
    dir_rows = {dir_rows, t};
  endtask

  initial begin
    int phase, n, i;
    qx = '0; qy = '0; qz = '0; parity = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, query at the origin after reset
    add_row(-10, -10, 5, 10, -10, 5, 0, 10, 5, 1, 1);     // wholly above
    add_row(-10, -10, -5, 10, -10, -5, 0, 10, -5, 1, 0);  // wholly below
    add_row(-10, -10, -5, 10, -10, 5, 0, 10, 5, 1, -1);   // plane test
    add_row(0, 0, 5, 10, 0, 5, 0, 10, 5, 1, 1);           // vertex on query xy
    add_row(-10, 0, 5, 10, 0, 5, 0, 10, 5, 1, 1);         // edge through point
    add_row(0, 0, 5, 10, 10, 5, 20, 20, 5, 1, 0);         // degenerate
    add_row(20, 20, 5, 30, 20, 5, 20, 30, 5, 1, 0);       // outside xy
    add_row(-10, -10, 0, 10, -10, 0, 0, 10, 0, 1, 0);     // coplanar with point
    add_row(-10, -10, 5, 10, -10, 5, 0, 10, 5, 0, -1);    // two hits cancel
    add_row(-10, -10, 5, 0, 10, 5, 10, -10, 5, 1, 0);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
            32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
            32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000, 1, -1);
    add_row(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
            32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 0);
    foreach (dir_rows[k]) send_tri(dir_rows[k]);
    drain();

    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        3: begin send_idle_pct = 33; recv_stall_pct = 33; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      case (phase)
        0: begin cfg_write(REG_QX, 32'h7fff_fff0); cfg_write(REG_QY, 32'h8000_0010);
                 cfg_write(REG_QZ, 32'h8000_0000); end
        1: begin cfg_write(REG_QX, 32'h8000_0040); cfg_write(REG_QY, 32'h7fff_ffc0);
                 cfg_write(REG_QZ, 32'h7fff_ffff); end
        default: begin cfg_write(REG_QX, $urandom()); cfg_write(REG_QY, $urandom());
                       cfg_write(REG_QZ, ($urandom_range(1)) ? $urandom() : 32'h0001_0000);
                 end
      endcase
      if (phase == 5) begin
        // long hold-off while the sender keeps pushing
        fork
          begin hold_off = 1'b1; repeat (3000) @(posedge clk); hold_off = 1'b0; end
        join_none
      end
      for (i = 0; i < 100; i += n) begin
        n = $urandom_range(1, 4);
        for (int j = 0; j < n; j++) send_tri(rnd_tri(j == n - 1));
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_point_in_mesh_parity_test_core: done, clean");
    end else begin
      $display("tb_point_in_mesh_parity_test_core: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+design
design/pimpt_pkg.sv
design/pimpt_if.sv
design/pimpt_front.sv
design/pimpt_queue.sv
design/pimpt_mac.sv
design/pimpt_back.sv
design/point_in_mesh_parity_test_core.sv
verif/tb_point_in_mesh_parity_test_core.sv
